/* hdl/lfodly_pkg.sv */
// Shared types, constants and helpers for the LFO with delayed fade-in.
// Used by lfodly_osc, lfodly_mul and lfo_with_delay_envelope_unit.
// No dependencies.
package lfodly_pkg;

    // Field and datapath widths
    localparam int unsigned PHASE_FRAC_BITS_DEF = 6;
    localparam int unsigned SPEED_W             = 22;
    localparam int unsigned IDX_W               = 16;
    localparam int unsigned LEVEL_W             = 16;
    localparam int unsigned MUL_W               = 18;
    localparam int unsigned PROD_W              = 2 * MUL_W;
    localparam int unsigned QUOT_W              = PROD_W - 15;
    localparam int unsigned CFG_INDEX_W         = 3;
    localparam int unsigned CFG_DATA_W          = 22;

    // Arithmetic constants
    localparam logic [15:0] FULL_SCALE   = 16'h8000;
    localparam logic [16:0] ATTACK_BASE  = 17'h08001;
    localparam logic [31:0] LFSR_TAPS    = 32'hd0000001;
    localparam logic [31:0] NOISE_SEED   = 32'h00000001;
    localparam logic signed [16:0] TRI_PEAK = 17'sd16383;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_TIME  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_DEPTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AMP_DEPTH   = 3'd4;

    // Waveform codes
    localparam logic [1:0] WAVE_SAW      = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;
    localparam logic [1:0] WAVE_SH       = 2'd3;

    // Item modes
    localparam logic MODE_TRIGGER = 1'b0;

    typedef struct packed {
        logic        mode;
        logic [15:0] range_low;
        logic [15:0] range_high;
        logic [15:0] pitch_amount_ctl;
        logic [15:0] amp_amount_ctl;
    } in_item_t;

    typedef struct packed {
        logic signed [16:0] pitch_offset;
        logic [14:0]        amp_value;
    } out_item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [1:0]         waveform;
        logic [15:0]        delay_time;
    } osc_cfg_t;

    typedef struct packed {
        logic step;
        logic trigger;
    } osc_ctl_t;

    // Divide a product by 0x8000, truncating toward zero
    function automatic logic signed [QUOT_W-1:0] div_fs_trunc(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] adj;
        adj = p[PROD_W-1] ? (p + PROD_W'(32767)) : p;
        return adj[PROD_W-1:15];
    endfunction

endpackage

/* hdl/lfodly_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on lfodly_pkg for operand and product widths.
module lfodly_mul (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [lfodly_pkg::MUL_W-1:0]    a,
    input  logic signed [lfodly_pkg::MUL_W-1:0]    b,
    output logic signed [lfodly_pkg::PROD_W-1:0]   prod
);

    logic signed [lfodly_pkg::PROD_W-1:0] prod_reg;

    // Capture the product on each issue, hold otherwise
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

/* hdl/lfodly_osc.sv */
// Oscillator state: phase accumulator, wave shaper, noise LFSR and
// delay/attack fade envelope. Depends on lfodly_pkg.
module lfodly_osc #(
    parameter int unsigned PHASE_FRAC_BITS = lfodly_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lfodly_pkg::osc_ctl_t  ctl,
    input  lfodly_pkg::osc_cfg_t  cfg,
    output logic [15:0]           env_level,
    output logic signed [15:0]    wave_sample
);

    localparam int unsigned ACC_W = lfodly_pkg::IDX_W + PHASE_FRAC_BITS;
    localparam int unsigned SUM_W =
        (ACC_W > lfodly_pkg::SPEED_W) ? ACC_W : lfodly_pkg::SPEED_W;

    typedef enum logic [3:0] {
        ENV_WAIT    = 4'b0001,
        ENV_DELAY   = 4'b0010,
        ENV_ATTACK  = 4'b0100,
        ENV_SUSTAIN = 4'b1000
    } env_phase_t;

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [31:0]        noise_reg, noise_next;
    logic               last_msb_reg, last_msb_next;
    logic signed [15:0] wave_reg, wave_next;
    env_phase_t         env_phase_reg, env_phase_next;
    logic [15:0]        env_level_reg, env_level_next;
    logic [15:0]        delay_cnt_reg, delay_cnt_next;

    logic [SUM_W-1:0]   acc_sum;
    logic [15:0]        idx;
    logic [15:0]        cnt_inc;
    logic [16:0]        att_step;
    logic [17:0]        att_sum;
    logic [13:0]        low14;
    logic signed [16:0] tri_w;
    logic [31:0]        lfsr_step;

    // Arithmetic shared by the tick path
    always_comb begin
        acc_sum   = SUM_W'(acc_reg) + SUM_W'(cfg.speed);
        idx       = acc_sum[PHASE_FRAC_BITS +: lfodly_pkg::IDX_W];
        cnt_inc   = delay_cnt_reg + 16'd1;
        att_step  = lfodly_pkg::ATTACK_BASE - {1'b0, cfg.delay_time};
        att_sum   = {2'b00, env_level_reg} + {1'b0, att_step};
        low14     = idx[13:0];
        lfsr_step = {1'b0, noise_reg[31:1]} ^
                    (noise_reg[0] ? lfodly_pkg::LFSR_TAPS : 32'd0);
        unique case (idx[15:14])
            2'b00:   tri_w = {3'b000, low14};
            2'b01:   tri_w = lfodly_pkg::TRI_PEAK - signed'({3'b000, low14});
            2'b10:   tri_w = 17'sd0 - signed'({3'b000, low14});
            default: tri_w = signed'({3'b000, low14}) - lfodly_pkg::TRI_PEAK;
        endcase
    end

    // Next state: trigger clears, tick steps envelope then wave
    always_comb begin
        acc_next       = acc_reg;
        noise_next     = noise_reg;
        last_msb_next  = last_msb_reg;
        wave_next      = wave_reg;
        env_phase_next = env_phase_reg;
        env_level_next = env_level_reg;
        delay_cnt_next = delay_cnt_reg;

        if (ctl.trigger) begin
            acc_next       = '0;
            delay_cnt_next = '0;
            env_level_next = '0;
            env_phase_next = (cfg.delay_time == 16'd0) ? ENV_ATTACK : ENV_DELAY;
        end else if (ctl.step) begin
            // Envelope
            case (env_phase_reg)
                ENV_DELAY: begin
                    delay_cnt_next = cnt_inc;
                    if (cnt_inc >= cfg.delay_time) begin
                        env_phase_next = ENV_ATTACK;
                    end
                end
                ENV_ATTACK: begin
                    if (cfg.delay_time > lfodly_pkg::ATTACK_BASE[15:0]) begin
                        env_level_next = lfodly_pkg::FULL_SCALE;
                        env_phase_next = ENV_SUSTAIN;
                    end else if (att_sum >= {2'b00, lfodly_pkg::FULL_SCALE}) begin
                        env_level_next = lfodly_pkg::FULL_SCALE;
                        env_phase_next = ENV_SUSTAIN;
                    end else begin
                        env_level_next = att_sum[15:0];
                    end
                end
                default: begin
                end
            endcase

            // Wave
            acc_next = acc_sum[ACC_W-1:0];
            unique case (cfg.waveform)
                lfodly_pkg::WAVE_SAW: begin
                    wave_next = {~idx[15], idx[14:0]};
                end
                lfodly_pkg::WAVE_TRIANGLE: begin
                    wave_next = {tri_w[14:0], 1'b0};
                end
                lfodly_pkg::WAVE_SQUARE: begin
                    wave_next = idx[15] ? 16'sh7fff : 16'sh8000;
                end
                default: begin
                    // Sample and hold: step noise on a rising index MSB
                    if (idx[15] && !last_msb_reg) begin
                        noise_next = lfsr_step;
                        wave_next  = lfsr_step[15:0];
                    end else begin
                        wave_next  = noise_reg[15:0];
                    end
                    last_msb_next = idx[15];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            noise_reg     <= lfodly_pkg::NOISE_SEED;
            last_msb_reg  <= 1'b0;
            wave_reg      <= '0;
            env_phase_reg <= ENV_WAIT;
            env_level_reg <= '0;
            delay_cnt_reg <= '0;
        end else begin
            acc_reg       <= acc_next;
            noise_reg     <= noise_next;
            last_msb_reg  <= last_msb_next;
            wave_reg      <= wave_next;
            env_phase_reg <= env_phase_next;
            env_level_reg <= env_level_next;
            delay_cnt_reg <= delay_cnt_next;
        end
    end

    assign env_level   = env_level_reg;
    assign wave_sample = wave_reg;

endmodule

/* hdl/lfo_with_delay_envelope_unit.sv */
// Top level of the LFO with delayed fade-in: sequencer, configuration
// registers and result register. Depends on lfodly_pkg, lfodly_osc, lfodly_mul.

// Each item passes through the sequencer states in order up to a loaded result:
// S_IDLE takes the item, S_ADV steps the envelope and oscillator (or applies a
// note trigger), S_M0 to S_M4 are five issue slots of the single shared 18x18
// multiplier (two envelope depth products, range times sample, amplitude
// scaling, pitch scaling), and S_DONE loads the result register. The block has
// no other multiplier, so its five passes set the item time; s_ready is high
// only while the sequencer is idle and out of reset. A finished result waits in
// its own register, so the next item is taken while the previous result is
// still unread; a result stalls the sequencer only if the one before it has not
// been taken yet. Configuration writes are ready whenever the block is out of
// reset and must be made while the block is idle.
module lfo_with_delay_envelope_unit #(
    parameter int unsigned PHASE_FRAC_BITS = lfodly_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  lfodly_pkg::in_item_t                  s_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output lfodly_pkg::out_item_t                 m_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lfodly_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfodly_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ADV  = 8'b0000_0010,
        S_M0   = 8'b0000_0100,
        S_M1   = 8'b0000_1000,
        S_M2   = 8'b0001_0000,
        S_M3   = 8'b0010_0000,
        S_M4   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    logic [lfodly_pkg::SPEED_W-1:0] speed_reg;
    logic [1:0]                     waveform_reg;
    logic [15:0]                    delay_time_reg;
    logic [15:0]                    pitch_depth_reg;
    logic [15:0]                    amp_depth_reg;

    lfodly_pkg::in_item_t  in_reg;
    lfodly_pkg::out_item_t out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;

    logic [15:0]        pamt_reg, pamt_next;
    logic [15:0]        aamt_reg, aamt_next;
    logic signed [16:0] pv1_reg, pv1_next;
    logic [14:0]        av_reg, av_next;

    lfodly_pkg::osc_cfg_t osc_cfg;
    lfodly_pkg::osc_ctl_t osc_ctl;
    logic [15:0]          env_level;
    logic signed [15:0]   wave_sample;

    logic                                 mul_en;
    logic signed [lfodly_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [lfodly_pkg::PROD_W-1:0] prod;
    logic signed [lfodly_pkg::QUOT_W-1:0] quot;

    logic [15:0] amt_ctl;
    logic [16:0] amt_sum;
    logic [15:0] amt_clamped;
    logic [15:0] range_sel;
    logic [14:0] av0;
    logic        out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg       <= '0;
            waveform_reg    <= '0;
            delay_time_reg  <= '0;
            pitch_depth_reg <= '0;
            amp_depth_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lfodly_pkg::REG_SPEED:       speed_reg       <= cfg_data;
                lfodly_pkg::REG_WAVEFORM:    waveform_reg    <= cfg_data[1:0];
                lfodly_pkg::REG_DELAY_TIME:  delay_time_reg  <= cfg_data[15:0];
                lfodly_pkg::REG_PITCH_DEPTH: pitch_depth_reg <= cfg_data[15:0];
                lfodly_pkg::REG_AMP_DEPTH:   amp_depth_reg   <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = aresetn;

    assign osc_cfg.speed      = speed_reg;
    assign osc_cfg.waveform   = waveform_reg;
    assign osc_cfg.delay_time = delay_time_reg;

    assign osc_ctl.step    = (state_reg == S_ADV) && (in_reg.mode != lfodly_pkg::MODE_TRIGGER);
    assign osc_ctl.trigger = (state_reg == S_ADV) && (in_reg.mode == lfodly_pkg::MODE_TRIGGER);

    lfodly_osc #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_osc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (osc_ctl),
        .cfg         (osc_cfg),
        .env_level   (env_level),
        .wave_sample (wave_sample)
    );

    lfodly_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Scaled product and modulation amount clamp
    always_comb begin
        quot        = lfodly_pkg::div_fs_trunc(prod);
        amt_ctl     = (state_reg == S_M1) ? in_reg.pitch_amount_ctl : in_reg.amp_amount_ctl;
        amt_sum     = {1'b0, amt_ctl} + quot[16:0];
        amt_clamped = (amt_sum > {1'b0, lfodly_pkg::FULL_SCALE}) ?
                      lfodly_pkg::FULL_SCALE : amt_sum[15:0];
        range_sel   = (wave_sample <= 16'sd0) ? in_reg.range_low : in_reg.range_high;
        av0         = {~wave_sample[15], wave_sample[14:1]};
    end

    // Operand select for each multiplier pass
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_M0: begin
                mul_a = {2'b00, env_level};
                mul_b = {2'b00, pitch_depth_reg};
            end
            S_M1: begin
                mul_a = {2'b00, env_level};
                mul_b = {2'b00, amp_depth_reg};
            end
            S_M2: begin
                mul_a = {{2{wave_sample[15]}}, wave_sample};
                mul_b = {2'b00, range_sel};
            end
            S_M3: begin
                mul_a = {3'b000, av0};
                mul_b = {2'b00, aamt_reg};
            end
            S_M4: begin
                mul_a = {pv1_reg[16], pv1_reg};
                mul_b = {2'b00, pamt_reg};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer and result capture
    always_comb begin
        state_next = state_reg;
        pamt_next  = pamt_reg;
        aamt_next  = aamt_reg;
        pv1_next   = pv1_reg;
        av_next    = av_reg;
        out_next   = out_reg;
        out_free   = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_ADV;
                end
            end
            S_ADV: state_next = S_M0;
            S_M0:  state_next = S_M1;
            S_M1: begin
                pamt_next  = amt_clamped;
                state_next = S_M2;
            end
            S_M2: begin
                aamt_next  = amt_clamped;
                state_next = S_M3;
            end
            S_M3: begin
                pv1_next   = quot[16:0];
                state_next = S_M4;
            end
            S_M4: begin
                av_next    = quot[14:0];
                state_next = S_DONE;
            end
            S_DONE: begin
                // Load the result once the previous one has gone
                if (out_free) begin
                    out_next.pitch_offset = quot[16:0];
                    out_next.amp_value    = av_reg;
                    m_valid_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        pamt_reg <= pamt_next;
        aamt_reg <= aamt_next;
        pv1_reg  <= pv1_next;
        av_reg   <= av_next;
        out_reg  <= out_next;
    end

    assign s_ready = aresetn && (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

`ifndef SYNTHESIS
    // A result appears only from the final sequencer step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result valid raised outside the final step");

    // An accepted item starts the oscillator step next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_ADV))
        else $error("accepted item did not start the sequence");

    // Clamped modulation amounts never exceed full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_M4) |->
            (pamt_reg <= lfodly_pkg::FULL_SCALE) && (aamt_reg <= lfodly_pkg::FULL_SCALE))
        else $error("modulation amount above full scale");
`endif

endmodule

/* tb/sv/lfodly_tb_pkg.sv */
// Verification package for the LFO with delayed fade-in: settings type and the
// mirror class that predicts each result and checks the block's output items.
// Depends on lfodly_pkg.
package lfodly_tb_pkg;
    import lfodly_pkg::*;

    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        ENV_WAIT    = 2'd0,
        ENV_DELAY   = 2'd1,
        ENV_ATTACK  = 2'd2,
        ENV_SUSTAIN = 2'd3
    } env_phase_e;

    typedef struct {
        logic [SPEED_W-1:0] speed;
        logic [1:0]         waveform;
        logic [15:0]        delay_time;
        logic [15:0]        pitch_depth;
        logic [15:0]        amp_depth;
    } lfo_settings_t;

    class lfo_mirror;
        // register copies
        logic [SPEED_W-1:0] speed;
        logic [1:0]         waveform;
        logic [15:0]        delay_time;
        logic [15:0]        pitch_depth;
        logic [15:0]        amp_depth;
        // oscillator and envelope state
        logic [SPEED_W-1:0] phase_acc;
        logic [31:0]        noise;
        logic               last_msb;
        int                 sample;
        env_phase_e         env_phase;
        int unsigned        env_level;
        logic [15:0]        delay_count;
        // expected output items, oldest first
        out_item_t          mod_queue[$];
        int unsigned        mismatches;

        function new();
            speed       = '0;
            waveform    = WAVE_SAW;
            delay_time  = '0;
            pitch_depth = '0;
            amp_depth   = '0;
            phase_acc   = '0;
            noise       = NOISE_SEED;
            last_msb    = 1'b0;
            sample      = 0;
            env_phase   = ENV_WAIT;
            env_level   = 0;
            delay_count = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SPEED:       speed       = data[SPEED_W-1:0];
                REG_WAVEFORM:    waveform    = data[1:0];
                REG_DELAY_TIME:  delay_time  = data[15:0];
                REG_PITCH_DEPTH: pitch_depth = data[15:0];
                REG_AMP_DEPTH:   amp_depth   = data[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return mod_queue.size();
        endfunction

        // Step the delay/attack envelope by one tick
        function void step_envelope();
            int unsigned nxt;
            case (env_phase)
                ENV_DELAY: begin
                    delay_count = delay_count + 16'd1;
                    if (delay_count >= delay_time)
                        env_phase = ENV_ATTACK;
                end
                ENV_ATTACK: begin
                    if (32'(delay_time) > 32'h8001) begin
                        env_level = 32'h8000;
                        env_phase = ENV_SUSTAIN;
                    end else begin
                        nxt = env_level + (32'h8001 - 32'(delay_time));
                        if (nxt >= 32'h8000) begin
                            env_level = 32'h8000;
                            env_phase = ENV_SUSTAIN;
                        end else begin
                            env_level = nxt;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // Advance the phase and form the new wave sample
        function void step_wave();
            logic [15:0] idx;
            int          w;
            phase_acc = phase_acc + speed;
            idx = 16'(phase_acc >> PHASE_FRAC_BITS_DEF);
            case (waveform)
                WAVE_SAW: sample = int'(idx) - 32768;
                WAVE_TRIANGLE: begin
                    if (idx < 16'h4000)
                        w = int'(idx);
                    else if (idx < 16'h8000)
                        w = 16383 - int'(idx[13:0]);
                    else if (idx < 16'hc000)
                        w = -int'(idx[13:0]);
                    else
                        w = int'(idx[13:0]) - 16383;
                    sample = w * 2;
                end
                WAVE_SQUARE: sample = idx[15] ? 32767 : -32768;
                default: begin
                    // step the noise register on a rising index MSB only
                    if (idx[15] && !last_msb)
                        noise = (noise >> 1) ^ (noise[0] ? LFSR_TAPS : 32'h0);
                    last_msb = idx[15];
                    sample = int'($signed(noise[15:0]));
                end
            endcase
        endfunction

        function longint mod_amount(logic [15:0] ctl, logic [15:0] depth);
            longint a;
            a = longint'(ctl) + (longint'(env_level) * longint'(depth)) / 64'sd32768;
            return (a > 64'sd32768) ? 64'sd32768 : a;
        endfunction

        // Note an accepted input item and queue the result it causes
        function void take_item(in_item_t it);
            longint    rng;
            longint    pv;
            longint    av;
            out_item_t r;
            if (it.mode == MODE_TRIGGER) begin
                phase_acc   = '0;
                env_phase   = (delay_time == 16'd0) ? ENV_ATTACK : ENV_DELAY;
                delay_count = '0;
                env_level   = 0;
            end else begin
                step_envelope();
                step_wave();
            end
            rng = (sample <= 0) ? longint'(it.range_low) : longint'(it.range_high);
            pv  = (rng * longint'(sample)) / 64'sd32768;
            pv  = (pv * mod_amount(it.pitch_amount_ctl, pitch_depth)) / 64'sd32768;
            av  = longint'(sample + 32768) / 64'sd2;
            av  = (av * mod_amount(it.amp_amount_ctl, amp_depth)) / 64'sd32768;
            r.pitch_offset = pv[16:0];
            r.amp_value    = av[14:0];
            mod_queue.push_back(r);
        endfunction

        // Compare one output item with the oldest expectation
        function void check_output(out_item_t got);
            out_item_t want;
            if (mod_queue.size() == 0) begin
                $display("%0t: unexpected output item pitch_offset %0d amp_value %0d",
                         $time, $signed(got.pitch_offset), got.amp_value);
                mismatches++;
                return;
            end
            want = mod_queue.pop_front();
            if (got.pitch_offset !== want.pitch_offset) begin
                $display("%0t: pitch_offset expected %0d actual %0d",
                         $time, $signed(want.pitch_offset), $signed(got.pitch_offset));
                mismatches++;
            end
            if (got.amp_value !== want.amp_value) begin
                $display("%0t: amp_value expected %0d actual %0d",
                         $time, want.amp_value, got.amp_value);
                mismatches++;
            end
        endfunction
    endclass

endpackage

/* tb/sv/tb_lfo_with_delay_envelope_unit.sv */
// Top of the LFO with delayed fade-in testbench: clock, reset, drivers for the
// item and configuration channels, result sink and run control.
// Depends on lfodly_pkg, lfodly_tb_pkg and lfo_with_delay_envelope_unit.
module tb_lfo_with_delay_envelope_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lfodly_pkg::*;
    import lfodly_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned SETTLE       = 12;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    lfo_mirror     mirror = new();
    lfo_settings_t lfo_cfg;
    int unsigned   idle_max    = 0;
    int unsigned   sent_items  = 0;
    int unsigned   cycle_count = 0;

    lfo_with_delay_envelope_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Take output items with random stalls and check each one
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            mirror.check_output(m_item);
        end
    end

    function automatic in_item_t mk_item(logic mode, logic [15:0] rlo, logic [15:0] rhi,
                                         logic [15:0] pctl, logic [15:0] actl);
        in_item_t it;
        it.mode             = mode;
        it.range_low        = rlo;
        it.range_high       = rhi;
        it.pitch_amount_ctl = pctl;
        it.amp_amount_ctl   = actl;
        return it;
    endfunction

    // Mix of extremes, small values and full-range values
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_item(int unsigned trig_pct);
        logic mode;
        mode = ($urandom_range(0, 99) < trig_pct) ? MODE_TRIGGER : MODE_TICK;
        return mk_item(mode, pick16(), pick16(), pick16(), pick16());
    endfunction

    function automatic lfo_settings_t rand_settings();
        lfo_settings_t s;
        case ($urandom_range(0, 4))
            0: s.speed = '0;
            1: s.speed = '1;
            2: s.speed = SPEED_W'($urandom_range(0, 22'h03ffff));
            default: s.speed = SPEED_W'($urandom);
        endcase
        s.waveform = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0: s.delay_time = 16'd0;
            1: s.delay_time = 16'd1;
            2: s.delay_time = 16'd32768;
            3: s.delay_time = 16'd65535;
            4: s.delay_time = 16'd32769;
            default: s.delay_time = 16'($urandom_range(0, 24));
        endcase
        s.pitch_depth = pick16();
        s.amp_depth   = pick16();
        return s;
    endfunction

    // Write every register from a settings set; block must be idle
    task automatic apply_settings(lfo_settings_t s);
        logic [CFG_INDEX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0]  val [5];
        idx = '{REG_SPEED, REG_WAVEFORM, REG_DELAY_TIME, REG_PITCH_DEPTH, REG_AMP_DEPTH};
        val = '{CFG_DATA_W'(s.speed), CFG_DATA_W'(s.waveform), CFG_DATA_W'(s.delay_time),
                CFG_DATA_W'(s.pitch_depth), CFG_DATA_W'(s.amp_depth)};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (cfg_ready !== 1'b1);
            mirror.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        mirror.take_item(it);
        sent_items++;
    endtask

    // Hold off the sender until every expected item has come, then settle
    task automatic drain();
        s_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned n;
        int unsigned d;
        int unsigned tp;
        in_item_t    it;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, zero and full-scale fields
        send_item(mk_item(MODE_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(mk_item(MODE_TICK, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        drain();

        // Trigger keeps the held sample; zero delay goes straight to attack
        lfo_cfg = '{speed: '1, waveform: WAVE_SAW, delay_time: 16'd0,
                    pitch_depth: 16'hffff, amp_depth: 16'hffff};
        apply_settings(lfo_cfg);
        send_item(mk_item(MODE_TRIGGER, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_item(mk_item(MODE_TICK, 16'hffff, 16'hffff, 16'h0000, 16'h0000));
        drain();

        // Triangle across all four segments
        lfo_cfg.waveform = WAVE_TRIANGLE;
        lfo_cfg.speed    = 22'h0c0000;
        apply_settings(lfo_cfg);
        for (int i = 0; i < 5; i++)
            send_item(mk_item(MODE_TICK, 16'hffff, 16'h8000, 16'h4000, 16'h8000));
        drain();

        // Square toggling each tick
        lfo_cfg.waveform = WAVE_SQUARE;
        lfo_cfg.speed    = 22'h200000;
        apply_settings(lfo_cfg);
        for (int i = 0; i < 3; i++)
            send_item(mk_item(MODE_TICK, 16'h1234, 16'hfedc, 16'h8000, 16'h8000));
        drain();

        // Sample and hold; a trigger leaves the noise register alone
        lfo_cfg.waveform = WAVE_SH;
        lfo_cfg.speed    = 22'h100000;
        apply_settings(lfo_cfg);
        send_item(mk_item(MODE_TICK, 16'hffff, 16'hffff, 16'h8000, 16'h8000));
        send_item(mk_item(MODE_TICK, 16'hffff, 16'hffff, 16'h8000, 16'h8000));
        send_item(mk_item(MODE_TRIGGER, 16'hffff, 16'hffff, 16'h8000, 16'h8000));
        send_item(mk_item(MODE_TICK, 16'hffff, 16'hffff, 16'h8000, 16'h8000));
        drain();

        // Short delay into attack, then slow, zero and oversized attack steps
        lfo_cfg = '{speed: 22'h012345, waveform: WAVE_SAW, delay_time: 16'd3,
                    pitch_depth: 16'h4000, amp_depth: 16'hffff};
        apply_settings(lfo_cfg);
        send_item(mk_item(MODE_TRIGGER, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
        for (int i = 0; i < 3; i++)
            send_item(mk_item(MODE_TICK, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
        drain();
        lfo_cfg.delay_time = 16'd32760;
        apply_settings(lfo_cfg);
        for (int i = 0; i < 3; i++)
            send_item(mk_item(MODE_TICK, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
        drain();
        lfo_cfg.delay_time = 16'd32769;
        apply_settings(lfo_cfg);
        send_item(mk_item(MODE_TICK, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
        drain();
        lfo_cfg.delay_time = 16'd40000;
        apply_settings(lfo_cfg);
        send_item(mk_item(MODE_TICK, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
        drain();

        // Random phases: a trigger then ticks, some noisy, some slow attacks
        n = sent_items + RANDOM_ITEMS;
        while (sent_items < n) begin
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            lfo_cfg  = rand_settings();
            if ($urandom_range(0, 3) == 0) begin
                // land exactly in attack, then retarget the slope
                d = $urandom_range(1, 6);
                lfo_cfg.delay_time = 16'(d);
                apply_settings(lfo_cfg);
                send_item(rand_item(100));
                for (int i = 0; i < d; i++)
                    send_item(rand_item(0));
                drain();
                case ($urandom_range(0, 3))
                    0: lfo_cfg.delay_time = 16'd32769;
                    1: lfo_cfg.delay_time = 16'($urandom_range(32770, 65535));
                    default: lfo_cfg.delay_time = 16'($urandom_range(32000, 32768));
                endcase
                apply_settings(lfo_cfg);
                d = $urandom_range(40, 150);
                for (int i = 0; i < d; i++) begin
                    it = rand_item(0);
                    it.pitch_amount_ctl = 16'($urandom_range(0, 16'h03ff));
                    it.amp_amount_ctl   = 16'($urandom_range(0, 16'h03ff));
                    send_item(it);
                end
            end else begin
                apply_settings(lfo_cfg);
                case ($urandom_range(0, 3))
                    0: tp = 0;
                    1: tp = 30;
                    default: tp = 3;
                endcase
                send_item(rand_item(100));
                d = $urandom_range(60, 160);
                for (int i = 0; i < d; i++)
                    send_item(rand_item(tp));
            end
            drain();
        end

        idle_max = 0;
        drain();
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/lfodly_pkg.sv
hdl/lfodly_mul.sv
hdl/lfodly_osc.sv
hdl/lfo_with_delay_envelope_unit.sv
tb/sv/lfodly_tb_pkg.sv
tb/sv/tb_lfo_with_delay_envelope_unit.sv
